/* hdl/flash_page_loader_protocol_macros.svh */
// Assertion macros for the flash page loader protocol block.
`ifndef FLASH_PAGE_LOADER_PROTOCOL_MACROS_SVH
`define FLASH_PAGE_LOADER_PROTOCOL_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define FLPL_ASSERT_IMPLIES(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define FLPL_ASSERT_NEXT(name, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

/* hdl/flpl_pkg.sv */
// Shared types and constants for the flash page loader protocol block.
package flpl_pkg;

    localparam int PAGE_BYTES_DEFAULT  = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int ADDR_W = 22;
    localparam int LOADS_PER_FILL = 8;

    // incoming message kinds
    localparam logic [2:0] MSG_PAGE_START = 3'd0;
    localparam logic [2:0] MSG_FILL       = 3'd1;
    localparam logic [2:0] MSG_QUIT       = 3'd2;
    localparam logic [2:0] MSG_OTHER_G0   = 3'd3;

    localparam logic [3:0] LEN_START = 4'd2;
    localparam logic [3:0] LEN_FILL  = 4'd8;
    localparam logic [3:0] LEN_QUIT  = 4'd0;

    localparam logic [2:0] RLEN_NONE     = 3'd0;
    localparam logic [2:0] RLEN_LOAD     = 3'd1;
    localparam logic [2:0] RLEN_TWO      = 3'd2;
    localparam logic [2:0] RLEN_ANNOUNCE = 3'd5;

    // configuration register indexes
    localparam logic [2:0] REG_NODE_ID       = 3'd0;
    localparam logic [2:0] REG_BROADCAST_ID  = 3'd1;
    localparam logic [2:0] REG_CPU_TYPE      = 3'd2;
    localparam logic [2:0] REG_NODE_CLASS    = 3'd3;
    localparam logic [2:0] REG_VERSION_MAJOR = 3'd4;
    localparam logic [2:0] REG_VERSION_MINOR = 3'd5;

    typedef enum logic [2:0] {
        KIND_FILL_NEXT    = 3'd0,
        KIND_PAGE_WRITTEN = 3'd1,
        KIND_FILL_BREAK   = 3'd2,
        KIND_ANNOUNCE     = 3'd3,
        KIND_ERASE        = 3'd4,
        KIND_LOAD         = 3'd5,
        KIND_PROGRAM      = 3'd6,
        KIND_RESTART      = 3'd7
    } item_kind_t;

    typedef enum logic [2:0] {
        OP_ANNOUNCE = 3'd0,
        OP_START    = 3'd1,
        OP_RESTART  = 3'd2,
        OP_FILL     = 3'd3,
        OP_BREAK    = 3'd4
    } cmd_op_t;

    typedef struct packed {
        logic [8:0]  node_id;
        logic [8:0]  broadcast_id;
        logic [7:0]  cpu_type;
        logic [15:0] node_class;
        logic [7:0]  version_major;
        logic [7:0]  version_minor;
    } cfg_t;

    typedef struct packed {
        logic            action;
        logic [2:0]      msg_kind;
        logic [8:0]      sender_id;
        logic [3:0]      msg_length;
        logic [7:0][7:0] data;
    } msg_t;

    // classified work handed from front to back
    typedef struct packed {
        cmd_op_t              op;
        logic [7:0]           seq;
        logic [8:0]           dest;
        logic [7:0][7:0]      data;
        logic [ADDR_W-1:0]    addr;
        logic [ADDR_W-1:0]    base;
        logic [15:0]          block;
        logic [8:0]           remain;
        logic                 done;
    } cmd_t;

    typedef struct packed {
        item_kind_t        kind;
        logic [7:0]        seq;
        logic [8:0]        dest;
        logic [2:0]        len;
        logic [4:0][7:0]   payload;
        logic [ADDR_W-1:0] addr;
        logic              last;
    } out_item_t;

    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

/* hdl/flash_page_loader_protocol.sv */
// Top level of the flash page loader protocol block: ports, config registers and checks.
//
// Each accepted message or announce request gives zero to ten result words. The front end
// takes one message per cycle while the command queue (QUEUE_DEPTH entries) has room; the
// back end sends one result word per cycle from its output register while the receiver takes
// them, so a page fill occupies the output for 9 words, or 10 when it completes the page, an
// idle page start 2 and everything else 1. Messages that give no words (ignored ones, or session
// messages that only take a sequence number) are not queued. No clearing pass after reset.
`include "flash_page_loader_protocol_macros.svh"

module flash_page_loader_protocol #(
    parameter int PAGE_BYTES  = flpl_pkg::PAGE_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = flpl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic        clk,
    input  logic        rst_n,
    // slave stream
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [79:0] s_tdata,  // sender_id, msg_length, byte0..byte7, zero pad
    input  logic [3:0]  s_tuser,  // action, msg_kind
    // master stream
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [87:0] m_tdata,  // sequence_number, dest_id, reply_length, payload0..payload4,
                                  // flash_address, zero pad
    output logic [2:0]  m_tuser,  // item_kind
    output logic        m_tlast,
    // configuration
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import flpl_pkg::*;

    cfg_t      cfg_reg;
    msg_t      msg;
    cmd_t      push_cmd;
    cmd_t      head;
    q_status_t q_status;
    out_item_t out_item;
    logic      push;
    logic      pop;
    logic      cfg_write;
    logic [2:0] reg_index;
    logic      reply_out;
    logic      cmd_out;
    logic      load_out;
    logic      work_ready;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_index = paddr[4:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.node_id       <= 9'd0;
            cfg_reg.broadcast_id  <= 9'd511;
            cfg_reg.cpu_type      <= 8'd0;
            cfg_reg.node_class    <= 16'd0;
            cfg_reg.version_major <= 8'd1;
            cfg_reg.version_minor <= 8'd0;
        end
        else if (cfg_write)
        begin
            case (reg_index)
                REG_NODE_ID:       cfg_reg.node_id       <= pwdata[8:0];
                REG_BROADCAST_ID:  cfg_reg.broadcast_id  <= pwdata[8:0];
                REG_CPU_TYPE:      cfg_reg.cpu_type      <= pwdata[7:0];
                REG_NODE_CLASS:    cfg_reg.node_class    <= pwdata[15:0];
                REG_VERSION_MAJOR: cfg_reg.version_major <= pwdata[7:0];
                REG_VERSION_MINOR: cfg_reg.version_minor <= pwdata[7:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        case (reg_index)
            REG_NODE_ID:       prdata = {23'd0, cfg_reg.node_id};
            REG_BROADCAST_ID:  prdata = {23'd0, cfg_reg.broadcast_id};
            REG_CPU_TYPE:      prdata = {24'd0, cfg_reg.cpu_type};
            REG_NODE_CLASS:    prdata = {16'd0, cfg_reg.node_class};
            REG_VERSION_MAJOR: prdata = {24'd0, cfg_reg.version_major};
            REG_VERSION_MINOR: prdata = {24'd0, cfg_reg.version_minor};
            default:           prdata = 32'd0;
        endcase
    end

    assign msg.action     = s_tuser[0];
    assign msg.msg_kind   = s_tuser[3:1];
    assign msg.sender_id  = s_tdata[8:0];
    assign msg.msg_length = s_tdata[12:9];
    assign msg.data       = s_tdata[76:13];

    flpl_front #(
        .PAGE_BYTES (PAGE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_valid  (s_tvalid),
        .s_ready  (s_tready),
        .msg      (msg),
        .cfg      (cfg_reg),
        .q_status (q_status),
        .push     (push),
        .cmd      (push_cmd)
    );

    flpl_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .head     (head),
        .status   (q_status)
    );

    flpl_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_status  (q_status),
        .pop       (pop),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_item  (out_item)
    );

    assign m_tdata = {6'd0, out_item.addr, out_item.payload, out_item.len,
                      out_item.dest, out_item.seq};
    assign m_tuser = out_item.kind;
    assign m_tlast = out_item.last;

    assign reply_out  = m_tvalid && (out_item.kind inside {KIND_FILL_NEXT, KIND_PAGE_WRITTEN,
                                                           KIND_FILL_BREAK, KIND_ANNOUNCE});
    assign cmd_out    = m_tvalid && (out_item.kind inside {KIND_ERASE, KIND_LOAD, KIND_PROGRAM,
                                                           KIND_RESTART});
    assign load_out   = m_tvalid && (out_item.kind == KIND_LOAD);
    assign work_ready = !q_status.empty && (!m_tvalid || m_tready);

    // replies never carry a flash address
    `FLPL_ASSERT_IMPLIES(a_reply_no_addr, reply_out, out_item.addr == '0, "reply has address")
    // flash commands carry no sequence number and no destination
    `FLPL_ASSERT_IMPLIES(a_cmd_no_seq, cmd_out, m_tdata[16:0] == '0, "command has reply fields")
    // a byte load is never the final word of a message
    `FLPL_ASSERT_IMPLIES(a_load_not_last, load_out, !m_tlast, "byte load marked last")
    // queued work reaches the output register without a bubble
    `FLPL_ASSERT_NEXT(a_drain, work_ready, m_tvalid, "back end stalled")

endmodule

/* hdl/flpl_front.sv */
// Front end: accepts messages, keeps session state and classifies each into a command.
module flpl_front #(
    parameter int PAGE_BYTES = flpl_pkg::PAGE_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_valid,
    output logic              s_ready,
    input  flpl_pkg::msg_t    msg,
    input  flpl_pkg::cfg_t    cfg,
    input  flpl_pkg::q_status_t q_status,
    output logic              push,
    output flpl_pkg::cmd_t    cmd
);
    import flpl_pkg::*;

    localparam logic [8:0] PAGE_W = 9'(PAGE_BYTES);

    logic [7:0]        seq_reg, seq_next;
    logic              in_session_reg, in_session_next;
    logic [15:0]       block_reg, block_next;
    logic [ADDR_W-1:0] base_reg, base_next;
    logic [8:0]        sender_reg, sender_next;
    logic [8:0]        left_reg, left_next;
    logic [ADDR_W-1:0] load_addr_reg, load_addr_next;

    logic              accept;
    logic              own;
    logic [15:0]       new_block;
    logic [24:0]       product;
    logic [ADDR_W-1:0] new_base;
    logic [8:0]        remain;

    assign s_ready   = !q_status.full;
    assign accept    = s_valid && s_ready;
    assign own       = (msg.sender_id == sender_reg);
    assign new_block = {msg.data[0], msg.data[1]};
    assign product   = 25'(new_block) * 25'(PAGE_W);
    assign new_base  = product[ADDR_W-1:0];
    assign remain    = (left_reg > 9'(LOADS_PER_FILL)) ? left_reg - 9'(LOADS_PER_FILL) : 9'd0;

    always_comb
    begin
        seq_next        = seq_reg;
        in_session_next = in_session_reg;
        block_next      = block_reg;
        base_next       = base_reg;
        sender_next     = sender_reg;
        left_next       = left_reg;
        load_addr_next  = load_addr_reg;
        push            = 1'b0;
        cmd             = '0;
        cmd.seq         = seq_reg;
        if (accept)
        begin
            if (!in_session_reg)
            begin
                if (msg.action)
                begin
                    cmd.op      = OP_ANNOUNCE;
                    cmd.dest    = cfg.broadcast_id;
                    cmd.data[0] = cfg.version_major;
                    cmd.data[1] = cfg.version_minor;
                    cmd.data[2] = cfg.cpu_type;
                    cmd.data[3] = cfg.node_class[15:8];
                    cmd.data[4] = cfg.node_class[7:0];
                    push        = 1'b1;
                    seq_next    = seq_reg + 8'd1;
                end
                else if (msg.msg_kind == MSG_PAGE_START && msg.msg_length == LEN_START)
                begin
                    cmd.op          = OP_START;
                    cmd.dest        = msg.sender_id;
                    cmd.data[0]     = {7'd0, PAGE_W[8]};
                    cmd.data[1]     = PAGE_W[7:0];
                    cmd.addr        = new_base;
                    push            = 1'b1;
                    seq_next        = seq_reg + 8'd1;
                    in_session_next = 1'b1;
                    block_next      = new_block;
                    base_next       = new_base;
                    sender_next     = msg.sender_id;
                    left_next       = PAGE_W;
                    load_addr_next  = new_base;
                end
                else if (msg.msg_kind == MSG_QUIT && msg.msg_length == LEN_QUIT)
                begin
                    cmd.op = OP_RESTART;
                    push   = 1'b1;
                end
            end
            else if (!msg.action)
            begin
                // every non-action message inside a session takes a sequence number
                seq_next = seq_reg + 8'd1;
                if (own && msg.msg_kind == MSG_FILL && msg.msg_length == LEN_FILL)
                begin
                    cmd.op         = OP_FILL;
                    cmd.dest       = sender_reg;
                    cmd.data       = msg.data;
                    cmd.addr       = load_addr_reg;
                    cmd.base       = base_reg;
                    cmd.block      = block_reg;
                    cmd.remain     = remain;
                    cmd.done       = (remain == 9'd0);
                    push           = 1'b1;
                    left_next      = remain;
                    load_addr_next = load_addr_reg + ADDR_W'(LOADS_PER_FILL);
                    if (remain == 9'd0)
                    begin
                        in_session_next = 1'b0;
                    end
                end
                else if (own && (msg.msg_kind inside {[MSG_PAGE_START:MSG_OTHER_G0]}))
                begin
                    cmd.op          = OP_BREAK;
                    cmd.dest        = sender_reg;
                    push            = 1'b1;
                    in_session_next = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            seq_reg        <= '0;
            in_session_reg <= 1'b0;
            block_reg      <= '0;
            base_reg       <= '0;
            sender_reg     <= '0;
            left_reg       <= '0;
            load_addr_reg  <= '0;
        end
        else
        begin
            seq_reg        <= seq_next;
            in_session_reg <= in_session_next;
            block_reg      <= block_next;
            base_reg       <= base_next;
            sender_reg     <= sender_next;
            left_reg       <= left_next;
            load_addr_reg  <= load_addr_next;
        end
    end

endmodule

/* hdl/flpl_queue.sv */
// Small command queue between the front end and the back end.
module flpl_queue #(
    parameter int DEPTH = flpl_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  flpl_pkg::cmd_t      push_cmd,
    input  logic                pop,
    output flpl_pkg::cmd_t      head,
    output flpl_pkg::q_status_t status
);
    import flpl_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
    localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

    cmd_t             entry_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             do_push, do_pop;

    assign status.full  = (count_reg == CNT_FULL);
    assign status.empty = (count_reg == '0);
    assign do_push      = push && !status.full;
    assign do_pop       = pop && !status.empty;
    assign head         = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_LAST) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_LAST) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (do_pop && !do_push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

/* hdl/flpl_back.sv */
// Back end: steps through each queued command and emits its result words.
module flpl_back (
    input  logic                   clk,
    input  logic                   rst_n,
    input  flpl_pkg::cmd_t         head,
    input  flpl_pkg::q_status_t    q_status,
    output logic                   pop,
    output logic                   out_valid,
    input  logic                   out_ready,
    output flpl_pkg::out_item_t    out_item
);
    import flpl_pkg::*;

    localparam logic [3:0] STEP_PROG = 4'(LOADS_PER_FILL);

    logic [3:0] step_reg, step_next;
    logic       valid_reg, valid_next;
    out_item_t  item_reg, item_next;
    out_item_t  item;
    logic [3:0] last_step;
    logic       fire;

    assign fire      = !q_status.empty && (!valid_reg || out_ready);
    assign out_valid = valid_reg;
    assign out_item  = item_reg;

    always_comb
    begin
        item      = '0;
        last_step = 4'd0;
        case (head.op)
            OP_ANNOUNCE:
            begin
                item.kind    = KIND_ANNOUNCE;
                item.seq     = head.seq;
                item.dest    = head.dest;
                item.len     = RLEN_ANNOUNCE;
                item.payload = head.data[4:0];
            end
            OP_START:
            begin
                last_step = 4'd1;
                if (step_reg == 4'd0)
                begin
                    item.kind       = KIND_FILL_NEXT;
                    item.seq        = head.seq;
                    item.dest       = head.dest;
                    item.len        = RLEN_TWO;
                    item.payload[0] = head.data[0];
                    item.payload[1] = head.data[1];
                end
                else
                begin
                    item.kind = KIND_ERASE;
                    item.addr = head.addr;
                end
            end
            OP_RESTART:
            begin
                item.kind = KIND_RESTART;
            end
            OP_FILL:
            begin
                last_step = head.done ? STEP_PROG + 4'd1 : STEP_PROG;
                if (step_reg < STEP_PROG)
                begin
                    item.kind       = KIND_LOAD;
                    item.len        = RLEN_LOAD;
                    item.payload[0] = head.data[step_reg[2:0]];
                    item.addr       = head.addr + ADDR_W'(step_reg[2:0]);
                end
                else if (step_reg == STEP_PROG && head.done)
                begin
                    item.kind = KIND_PROGRAM;
                    item.addr = head.base;
                end
                else if (step_reg == STEP_PROG)
                begin
                    item.kind       = KIND_FILL_NEXT;
                    item.seq        = head.seq;
                    item.dest       = head.dest;
                    item.len        = RLEN_TWO;
                    item.payload[0] = {7'd0, head.remain[8]};
                    item.payload[1] = head.remain[7:0];
                end
                else
                begin
                    item.kind       = KIND_PAGE_WRITTEN;
                    item.seq        = head.seq;
                    item.dest       = head.dest;
                    item.len        = RLEN_TWO;
                    item.payload[0] = head.block[15:8];
                    item.payload[1] = head.block[7:0];
                end
            end
            OP_BREAK:
            begin
                item.kind = KIND_FILL_BREAK;
                item.seq  = head.seq;
                item.dest = head.dest;
                item.len  = RLEN_NONE;
            end
            default:
            begin
                item = '0;
            end
        endcase
        item.last = (step_reg == last_step);
    end

    always_comb
    begin
        step_next  = step_reg;
        valid_next = valid_reg;
        item_next  = item_reg;
        pop        = 1'b0;
        if (fire)
        begin
            item_next  = item;
            valid_next = 1'b1;
            if (step_reg == last_step)
            begin
                pop       = 1'b1;
                step_next = 4'd0;
            end
            else
            begin
                step_next = step_reg + 4'd1;
            end
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg  <= '0;
            valid_reg <= 1'b0;
        end
        else
        begin
            step_reg  <= step_next;
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        item_reg <= item_next;
    end

endmodule

/* dv/tb_flash_page_loader_protocol.sv */
// Stream testbench for the flash page loader protocol block with a self-checking scoreboard.
module tb_flash_page_loader_protocol;
    timeunit 1ns;
    timeprecision 1ps;

    import flpl_pkg::*;

    // Tracks loader session state and holds the words the block owes.
    class page_loader_board;
        logic [8:0]  node_id;
        logic [8:0]  broadcast_id;
        logic [7:0]  cpu_type;
        logic [15:0] node_class;
        logic [7:0]  ver_major;
        logic [7:0]  ver_minor;

        logic [7:0]  seq_ctr;
        bit          in_session;
        logic [15:0] session_block;
        logic [8:0]  session_sender;
        logic [8:0]  bytes_left;
        logic [21:0] load_addr;

        out_item_t   pending_words[$];
        int          mismatches;

        function new();
            node_id = '0;
            broadcast_id = 9'd511;
            cpu_type = '0;
            node_class = '0;
            ver_major = 8'd1;
            ver_minor = '0;
            seq_ctr = '0;
            in_session = 1'b0;
            session_block = '0;
            session_sender = '0;
            bytes_left = '0;
            load_addr = '0;
            mismatches = 0;
        endfunction

        function void set_reg(logic [2:0] idx, logic [31:0] val);
            case (idx)
                REG_NODE_ID:       node_id = val[8:0];
                REG_BROADCAST_ID:  broadcast_id = val[8:0];
                REG_CPU_TYPE:      cpu_type = val[7:0];
                REG_NODE_CLASS:    node_class = val[15:0];
                REG_VERSION_MAJOR: ver_major = val[7:0];
                REG_VERSION_MINOR: ver_minor = val[7:0];
                default: ;
            endcase
        endfunction

        // reply words take the next sequence number
        function out_item_t reply(item_kind_t k, logic [8:0] dest, logic [2:0] len,
                                  logic [39:0] pl);
            out_item_t w;
            w = '0;
            w.kind = k;
            w.seq = seq_ctr;
            w.dest = dest;
            w.len = len;
            w.payload = pl;
            seq_ctr = seq_ctr + 8'd1;
            return w;
        endfunction

        function out_item_t command(item_kind_t k, logic [2:0] len, logic [7:0] b0,
                                    logic [21:0] addr);
            out_item_t w;
            w = '0;
            w.kind = k;
            w.len = len;
            w.payload = {32'h0, b0};
            w.addr = addr;
            return w;
        endfunction

        // Predicts the words for one accepted message; returns how many.
        function int note_message(msg_t m);
            out_item_t   step[$];
            logic [21:0] base;
            logic [15:0] page;
            int          i;
            page = 16'(PAGE_BYTES_DEFAULT);
            if (!in_session) begin
                if (m.action) begin
                    step.push_back(reply(KIND_ANNOUNCE, broadcast_id, RLEN_ANNOUNCE,
                        {node_class[7:0], node_class[15:8], cpu_type, ver_minor, ver_major}));
                end else if (m.msg_kind == MSG_PAGE_START && m.msg_length == LEN_START) begin
                    session_block = {m.data[0], m.data[1]};
                    base = 22'(32'(session_block) * PAGE_BYTES_DEFAULT);
                    step.push_back(reply(KIND_FILL_NEXT, m.sender_id, RLEN_TWO,
                        {24'h0, page[7:0], page[15:8]}));
                    step.push_back(command(KIND_ERASE, RLEN_NONE, 8'h0, base));
                    in_session = 1'b1;
                    session_sender = m.sender_id;
                    bytes_left = page[8:0];
                    load_addr = base;
                end else if (m.msg_kind == MSG_QUIT && m.msg_length == LEN_QUIT) begin
                    step.push_back(command(KIND_RESTART, RLEN_NONE, 8'h0, 22'h0));
                end
            end else if (!m.action) begin
                if (m.sender_id == session_sender && m.msg_kind == MSG_FILL
                        && m.msg_length == LEN_FILL) begin
                    for (i = 0; i < LOADS_PER_FILL; i++) begin
                        step.push_back(command(KIND_LOAD, RLEN_LOAD, m.data[i], load_addr));
                        load_addr = load_addr + 22'd1;
                    end
                    bytes_left = (bytes_left > 9'd8) ? bytes_left - 9'd8 : 9'd0;
                    if (bytes_left == 9'd0) begin
                        step.push_back(command(KIND_PROGRAM, RLEN_NONE, 8'h0,
                            22'(32'(session_block) * PAGE_BYTES_DEFAULT)));
                        step.push_back(reply(KIND_PAGE_WRITTEN, session_sender, RLEN_TWO,
                            {24'h0, session_block[7:0], session_block[15:8]}));
                        in_session = 1'b0;
                    end else begin
                        step.push_back(reply(KIND_FILL_NEXT, session_sender, RLEN_TWO,
                            {24'h0, bytes_left[7:0], 7'h0, bytes_left[8]}));
                    end
                end else if (m.sender_id == session_sender && m.msg_kind <= MSG_OTHER_G0) begin
                    step.push_back(reply(KIND_FILL_BREAK, session_sender, RLEN_NONE, 40'h0));
                    in_session = 1'b0;
                end else begin
                    // foreign or non-group-0 traffic still burns a sequence number
                    seq_ctr = seq_ctr + 8'd1;
                end
            end
            if (step.size() > 0)
                step[step.size() - 1].last = 1'b1;
            foreach (step[j])
                pending_words.push_back(step[j]);
            return step.size();
        endfunction

        task report(string what);
            $display("mismatch: %s", what);
            mismatches++;
        endtask

        task check_word(out_item_t got);
            out_item_t want;
            if (pending_words.size() == 0) begin
                report($sformatf("unexpected word kind %0d seq %0d addr %h",
                    got.kind, got.seq, got.addr));
                return;
            end
            want = pending_words.pop_front();
            if (got.kind !== want.kind || got.seq !== want.seq || got.dest !== want.dest
                    || got.len !== want.len || got.payload !== want.payload
                    || got.addr !== want.addr || got.last !== want.last)
                report($sformatf(
                    "got k%0d s%0d d%0d l%0d p%h a%h t%0d, want k%0d s%0d d%0d l%0d p%h a%h t%0d",
                    got.kind, got.seq, got.dest, got.len, got.payload, got.addr, got.last,
                    want.kind, want.seq, want.dest, want.len, want.payload, want.addr,
                    want.last));
        endtask
    endclass

    logic        clk;
    logic        rst_n = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [79:0] s_tdata = '0;
    logic [3:0]  s_tuser = '0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [87:0] m_tdata;
    logic [2:0]  m_tuser;
    logic        m_tlast;
    logic        psel = 1'b0;
    logic        penable = 1'b0;
    logic        pwrite = 1'b0;
    logic [4:0]  paddr = '0;
    logic [31:0] pwdata = '0;
    logic [31:0] prdata;
    logic        pready;

    int tx_idle_pct = 31;
    int rx_idle_pct = 63;

    page_loader_board board = new();

    flash_page_loader_protocol dut (
        .clk(clk),
        .rst_n(rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata(s_tdata),
        .s_tuser(s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata(m_tdata),
        .m_tuser(m_tuser),
        .m_tlast(m_tlast),
        .psel(psel),
        .penable(penable),
        .pwrite(pwrite),
        .paddr(paddr),
        .pwdata(pwdata),
        .prdata(prdata),
        .pready(pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk)
    begin
        if (!rst_n)
            m_tready <= 1'b0;
        else
            m_tready <= ($urandom_range(99) >= rx_idle_pct);
    end

    always @(posedge clk)
    begin
        out_item_t got;
        if (rst_n && m_tvalid && m_tready) begin
            got.kind = item_kind_t'(m_tuser);
            got.seq = m_tdata[7:0];
            got.dest = m_tdata[16:8];
            got.len = m_tdata[19:17];
            got.payload = m_tdata[59:20];
            got.addr = m_tdata[81:60];
            got.last = m_tlast;
            board.check_word(got);
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= 5'(idx) << 2;
        pwdata <= val;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        board.set_reg(idx, val);
    endtask

    task automatic write_config(input logic [8:0] nid, input logic [8:0] bid,
                                input logic [7:0] cpu, input logic [15:0] nt,
                                input logic [7:0] vmaj, input logic [7:0] vmin);
        write_reg(REG_NODE_ID, 32'(nid));
        write_reg(REG_BROADCAST_ID, 32'(bid));
        write_reg(REG_CPU_TYPE, 32'(cpu));
        write_reg(REG_NODE_CLASS, 32'(nt));
        write_reg(REG_VERSION_MAJOR, 32'(vmaj));
        write_reg(REG_VERSION_MINOR, 32'(vmin));
    endtask

    task automatic write_random_config();
        write_config(9'($urandom_range(511)), 9'($urandom_range(511)),
            8'($urandom_range(255)), 16'($urandom_range(65535)),
            8'($urandom_range(255)), 8'($urandom_range(255)));
    endtask

    task automatic send_msg(input msg_t m, output int words);
        while ($urandom_range(99) < tx_idle_pct) begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {3'b0, m.data, m.msg_length, m.sender_id};
        s_tuser <= {m.msg_kind, m.action};
        do @(posedge clk); while (!s_tready);
        words = board.note_message(m);
    endtask

    // let every owed word out, then idle for a margin
    task automatic drain();
        s_tvalid <= 1'b0;
        while (board.pending_words.size() != 0)
            @(posedge clk);
        repeat (30) @(posedge clk);
    endtask

    function automatic msg_t make_msg(logic act, logic [2:0] kind, logic [8:0] sender,
                                      logic [3:0] len, logic [63:0] bytes);
        msg_t m;
        m.action = act;
        m.msg_kind = kind;
        m.sender_id = sender;
        m.msg_length = len;
        m.data = bytes;
        return m;
    endfunction

    function automatic logic [7:0] rand_byte();
        int pick;
        pick = $urandom_range(7);
        if (pick == 0)
            return 8'h00;
        else if (pick == 1)
            return 8'hff;
        return 8'($urandom_range(255));
    endfunction

    // Mostly well-formed sessions with random content, the rest noise.
    function automatic msg_t random_message();
        msg_t m;
        int   pick;
        int   i;
        m.action = 1'b0;
        m.msg_kind = 3'($urandom_range(7));
        m.sender_id = 9'($urandom_range(511));
        m.msg_length = 4'($urandom_range(15));
        for (i = 0; i < 8; i++)
            m.data[i] = rand_byte();
        pick = $urandom_range(99);
        if (!board.in_session) begin
            if (pick < 55) begin
                m.msg_kind = MSG_PAGE_START;
                m.msg_length = LEN_START;
            end else if (pick < 65) begin
                m.action = 1'b1;
            end else if (pick < 73) begin
                m.msg_kind = MSG_QUIT;
                m.msg_length = LEN_QUIT;
            end
        end else begin
            if (pick < 75) begin
                m.sender_id = board.session_sender;
                m.msg_kind = MSG_FILL;
                m.msg_length = LEN_FILL;
            end else if (pick < 80) begin
                m.sender_id = board.session_sender;
                m.msg_kind = 3'($urandom_range(3));
            end else if (pick < 85) begin
                m.sender_id = board.session_sender;
                m.msg_kind = 3'(4 + $urandom_range(3));
            end else if (pick < 90) begin
                m.action = 1'b1;
            end
        end
        return m;
    endfunction

    task automatic run_random(input int count);
        int   done;
        int   n;
        msg_t m;
        done = 0;
        while (done < count) begin
            m = random_message();
            send_msg(m, n);
            done++;
        end
    endtask

    task automatic run_directed();
        int i;
        int n;
        send_msg(make_msg(1'b1, MSG_PAGE_START, 9'd0, 4'd0, 64'h0), n);
        drain();
        write_config(9'd0, 9'd0, 8'd0, 16'd0, 8'd0, 8'd0);
        send_msg(make_msg(1'b1, 3'd7, 9'd511, 4'd15, 64'hffff_ffff_ffff_ffff), n);
        drain();
        write_config(9'd511, 9'd511, 8'hff, 16'hffff, 8'hff, 8'hff);
        send_msg(make_msg(1'b1, MSG_PAGE_START, 9'd0, 4'd0, 64'h0), n);
        // ignored while idle, then a restart
        send_msg(make_msg(1'b0, MSG_FILL, 9'd3, LEN_FILL, 64'h0123_4567_89ab_cdef), n);
        send_msg(make_msg(1'b0, 3'd7, 9'd511, 4'd15, 64'hffff_ffff_ffff_ffff), n);
        send_msg(make_msg(1'b0, MSG_PAGE_START, 9'd5, 4'd3, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_QUIT, 9'd5, 4'd1, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_QUIT, 9'd5, LEN_QUIT, 64'h0), n);
        // full page at the top block, with foreign traffic mixed in
        send_msg(make_msg(1'b0, MSG_PAGE_START, 9'd511, LEN_START, 64'hffff), n);
        send_msg(make_msg(1'b1, MSG_PAGE_START, 9'd0, 4'd0, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_FILL, 9'd0, LEN_FILL, 64'h0), n);
        send_msg(make_msg(1'b0, 3'd4, 9'd511, LEN_FILL, 64'h0), n);
        for (i = 0; i < 8; i++)
            send_msg(make_msg(1'b0, MSG_FILL, 9'd511, LEN_FILL,
                (i % 2 == 0) ? 64'hffff_ffff_ffff_ffff : 64'h0), n);
        // session breaks: own quit, short fill, other group-0 kind
        send_msg(make_msg(1'b0, MSG_PAGE_START, 9'd0, LEN_START, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_FILL, 9'd0, LEN_FILL, 64'h8877_6655_4433_2211), n);
        send_msg(make_msg(1'b0, MSG_QUIT, 9'd0, LEN_QUIT, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_PAGE_START, 9'd7, LEN_START, 64'h1234), n);
        send_msg(make_msg(1'b0, MSG_FILL, 9'd7, 4'd7, 64'h0), n);
        send_msg(make_msg(1'b0, MSG_PAGE_START, 9'd8, LEN_START, 64'h8000), n);
        send_msg(make_msg(1'b0, MSG_OTHER_G0, 9'd8, 4'd8, 64'h0), n);
    endtask

    initial
    begin
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        run_directed();
        run_random(130);
        drain();
        write_random_config();
        tx_idle_pct = 63;
        rx_idle_pct = 31;
        run_random(130);
        drain();
        write_random_config();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        run_random(125);
        drain();
        if (board.mismatches == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("tb: failure");
        $finish;
    end

endmodule
